>>> rtl/core/jts_pkg.sv
// Shared types, character constants and decode functions of the JSON token scanner.
`default_nettype none

package jts_pkg;

    // Default depth of the queue of result groups between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Largest number of result words one text byte can cause.
    localparam int MAX_RESULTS = 3;

    // Character codes used by the lexer.
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;

    // Number of hex digits that follow a \u escape.
    localparam logic [2:0] HEX_DIGITS = 3'd4;

    // One result word as delivered on the output channel (without the last flag).
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       token_end;
        logic       token_single;
        logic       token_quoted;
        logic       stream_end;
    } res_t;

    // All result words caused by one text byte; cnt is 0 to 3.
    typedef struct packed {
        logic [1:0] cnt;
        res_t [MAX_RESULTS-1:0] res;
    } cmd_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Whitespace outside quotes.
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Punctuation characters that form a token of their own.
    function automatic logic is_single(input logic [7:0] c);
        logic r;
        unique case (c)
            8'h3D, 8'h3A, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h28, 8'h29,
            8'h2A, 8'h26, 8'h25, 8'h23, 8'h21, 8'h40, 8'h2C, 8'h27: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Value of a hex digit; any other character counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        priority if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
        else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
        else d = 8'h00;
        return d[3:0];
    endfunction

    // A result word that carries one token character.
    function automatic res_t data_res(input logic [7:0] c);
        res_t r;
        r = '0;
        r.data       = c;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    // A result word that closes the open token without a character.
    function automatic res_t close_res(input logic quoted);
        res_t r;
        r = '0;
        r.token_end    = 1'b1;
        r.token_quoted = quoted;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/jts_front.sv
// Front part: accepts text bytes, tracks lexer state and builds the result words of each byte.
`default_nettype none

module jts_front
    import jts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_input,
    output logic            push,
    output cmd_t            cmd
);

    logic        in_quotes_reg,  in_quotes_next;
    logic        escape_reg,     escape_next;
    logic [2:0]  hex_left_reg,   hex_left_next;
    logic [15:0] code_point_reg, code_point_next;
    logic        tok_open_reg,   tok_open_next;
    logic        has_bytes_reg,  has_bytes_next;
    logic        saw_quote_reg,  saw_quote_next;

    logic [15:0] cp_shift;

    // Code point with the current byte shifted in as the next hex digit.
    assign cp_shift = {code_point_reg[11:0], hex_value(text_byte)};

    // Next state and the result words of the current byte.
    always_comb
    begin
        in_quotes_next  = in_quotes_reg;
        escape_next     = escape_reg;
        hex_left_next   = hex_left_reg;
        code_point_next = code_point_reg;
        tok_open_next   = tok_open_reg;
        has_bytes_next  = has_bytes_reg;
        saw_quote_next  = saw_quote_reg;
        cmd             = '0;

        if (end_of_input)
        begin
            cmd.cnt = 2'd1;
            if (has_bytes_reg)
            begin
                cmd.res[0] = close_res(saw_quote_reg);
            end
            else
            begin
                cmd.res[0].stream_end = 1'b1;
            end
            in_quotes_next  = 1'b0;
            escape_next     = 1'b0;
            hex_left_next   = '0;
            code_point_next = '0;
            tok_open_next   = 1'b0;
            has_bytes_next  = 1'b0;
            saw_quote_next  = 1'b0;
        end
        else if (in_quotes_reg)
        begin
            if (hex_left_reg != 3'd0)
            begin
                code_point_next = cp_shift;
                hex_left_next   = hex_left_reg - 3'd1;
                if (hex_left_reg == 3'd1)
                begin
                    // Last hex digit: emit the code point as UTF-8.
                    tok_open_next  = 1'b1;
                    has_bytes_next = 1'b1;
                    if (cp_shift < 16'h0080)
                    begin
                        cmd.cnt    = 2'd1;
                        cmd.res[0] = data_res(cp_shift[7:0]);
                    end
                    else if (cp_shift < 16'h0800)
                    begin
                        cmd.cnt    = 2'd2;
                        cmd.res[0] = data_res({3'b110, cp_shift[10:6]});
                        cmd.res[1] = data_res({2'b10, cp_shift[5:0]});
                    end
                    else
                    begin
                        cmd.cnt    = 2'd3;
                        cmd.res[0] = data_res({4'b1110, cp_shift[15:12]});
                        cmd.res[1] = data_res({2'b10, cp_shift[11:6]});
                        cmd.res[2] = data_res({2'b10, cp_shift[5:0]});
                    end
                end
            end
            else if (escape_reg)
            begin
                escape_next = 1'b0;
                priority case (text_byte)
                    CH_BACKSLASH, CH_SLASH, CH_DQUOTE:
                    begin
                        cmd.cnt        = 2'd1;
                        cmd.res[0]     = data_res(text_byte);
                        tok_open_next  = 1'b1;
                        has_bytes_next = 1'b1;
                    end
                    CH_LOWER_N:
                    begin
                        cmd.cnt        = 2'd1;
                        cmd.res[0]     = data_res(CH_LF);
                        tok_open_next  = 1'b1;
                        has_bytes_next = 1'b1;
                    end
                    CH_LOWER_R:
                    begin
                        cmd.cnt        = 2'd1;
                        cmd.res[0]     = data_res(CH_CR);
                        tok_open_next  = 1'b1;
                        has_bytes_next = 1'b1;
                    end
                    CH_LOWER_B:
                    begin
                        cmd.cnt        = 2'd1;
                        cmd.res[0]     = data_res(CH_BS);
                        tok_open_next  = 1'b1;
                        has_bytes_next = 1'b1;
                    end
                    CH_LOWER_T:
                    begin
                        cmd.cnt        = 2'd1;
                        cmd.res[0]     = data_res(CH_TAB);
                        tok_open_next  = 1'b1;
                        has_bytes_next = 1'b1;
                    end
                    CH_LOWER_F:
                    begin
                        cmd.cnt        = 2'd1;
                        cmd.res[0]     = data_res(CH_FF);
                        tok_open_next  = 1'b1;
                        has_bytes_next = 1'b1;
                    end
                    CH_LOWER_U:
                    begin
                        hex_left_next   = HEX_DIGITS;
                        code_point_next = '0;
                    end
                    default:
                    begin
                        // An unknown escape character is dropped.
                        cmd.cnt = 2'd0;
                    end
                endcase
            end
            else if (text_byte == CH_DQUOTE)
            begin
                cmd.cnt        = 2'd1;
                cmd.res[0]     = close_res(saw_quote_reg);
                in_quotes_next = 1'b0;
                tok_open_next  = 1'b0;
                has_bytes_next = 1'b0;
                saw_quote_next = 1'b0;
            end
            else if (text_byte == CH_BACKSLASH)
            begin
                escape_next = 1'b1;
            end
            else
            begin
                cmd.cnt        = 2'd1;
                cmd.res[0]     = data_res(text_byte);
                tok_open_next  = 1'b1;
                has_bytes_next = 1'b1;
            end
        end
        else if (is_space(text_byte))
        begin
            if (tok_open_reg)
            begin
                cmd.cnt        = 2'd1;
                cmd.res[0]     = close_res(saw_quote_reg);
                tok_open_next  = 1'b0;
                has_bytes_next = 1'b0;
                saw_quote_next = 1'b0;
            end
        end
        else if (text_byte == CH_DQUOTE)
        begin
            in_quotes_next = 1'b1;
            saw_quote_next = 1'b1;
            tok_open_next  = 1'b1;
        end
        else if (is_single(text_byte))
        begin
            // Close an open token first, then the punctuation token itself.
            if (tok_open_reg)
            begin
                cmd.cnt    = 2'd2;
                cmd.res[0] = close_res(saw_quote_reg);
                cmd.res[1] = data_res(text_byte);
                cmd.res[1].token_end    = 1'b1;
                cmd.res[1].token_single = 1'b1;
            end
            else
            begin
                cmd.cnt    = 2'd1;
                cmd.res[0] = data_res(text_byte);
                cmd.res[0].token_end    = 1'b1;
                cmd.res[0].token_single = 1'b1;
            end
            tok_open_next  = 1'b0;
            has_bytes_next = 1'b0;
            saw_quote_next = 1'b0;
        end
        else
        begin
            cmd.cnt        = 2'd1;
            cmd.res[0]     = data_res(text_byte);
            tok_open_next  = 1'b1;
            has_bytes_next = 1'b1;
        end
    end

    // Only bytes that cause results enter the queue.
    assign push = accept && (cmd.cnt != 2'd0);

    // Lexer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg  <= 1'b0;
            escape_reg     <= 1'b0;
            hex_left_reg   <= '0;
            code_point_reg <= '0;
            tok_open_reg   <= 1'b0;
            has_bytes_reg  <= 1'b0;
            saw_quote_reg  <= 1'b0;
        end
        else if (accept)
        begin
            in_quotes_reg  <= in_quotes_next;
            escape_reg     <= escape_next;
            hex_left_reg   <= hex_left_next;
            code_point_reg <= code_point_next;
            tok_open_reg   <= tok_open_next;
            has_bytes_reg  <= has_bytes_next;
            saw_quote_reg  <= saw_quote_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/jts_queue.sv
// Short queue of result groups between the front and back parts.
`default_nettype none

module jts_queue
    import jts_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head_cmd,
    output q_status_t status
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    cmd_t            mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg,  count_next;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = mem[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CntW'(Depth));

endmodule

`default_nettype wire

>>> rtl/core/jts_back.sv
// Back part: walks the result words of each queued group into the output register.
`default_nettype none

module jts_back
    import jts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_t      head_cmd,
    input  wire q_status_t status,
    output logic           pop,
    input  wire logic      token_stall,
    output logic           token_valid,
    output res_t           res_out,
    output logic           last
);

    logic [1:0] idx_reg,   idx_next;
    logic       valid_reg, valid_next;
    res_t       res_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;

    // The output register takes a new word from a non-empty queue when empty or when its word is taken.
    assign load    = (!valid_reg || !token_stall) && !status.empty;
    assign is_last = (idx_reg == (head_cmd.cnt - 2'd1));
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!token_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= head_cmd.res[idx_reg];
            last_reg <= is_last;
        end
    end

    assign token_valid = valid_reg;
    assign res_out     = res_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

>>> rtl/core/json_token_scanner.sv
// The first result word of an accepted text byte is written into a queue entry and then loaded
// into the output register, from which it can be taken.
// Throughput: one text byte per cycle while the queue has room; the back part sends one
// result word per cycle while token_stall is low, so a byte's words leave one after another.
// The queue depth (QueueDepth entries) sets how long the front runs ahead of a stalled output.
// Reset (rst_n low, asynchronous) clears the lexer state, the queue and the output valid flag.
`default_nettype none

module json_token_scanner
    import jts_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       text_valid,
    output logic            text_stall,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_input,
    output logic            token_valid,
    input  wire logic       token_stall,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            token_end,
    output logic            token_single,
    output logic            token_quoted,
    output logic            stream_end,
    output logic            last
);

    logic      accept;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head_cmd;
    q_status_t status;
    res_t      res_out;

    // A byte is taken whenever the queue has a free entry.
    assign text_stall = status.full;
    assign accept     = text_valid && !text_stall;

    jts_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .text_byte    (text_byte),
        .end_of_input (end_of_input),
        .push         (push),
        .cmd          (push_cmd)
    );

    jts_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (status)
    );

    jts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .status      (status),
        .pop         (pop),
        .token_stall (token_stall),
        .token_valid (token_valid),
        .res_out     (res_out),
        .last        (last)
    );

    // Output word fields.
    assign out_byte     = res_out.data;
    assign byte_valid   = res_out.byte_valid;
    assign token_end    = res_out.token_end;
    assign token_single = res_out.token_single;
    assign token_quoted = res_out.token_quoted;
    assign stream_end   = res_out.stream_end;

endmodule

`default_nettype wire
